/* design/khs_pkg.sv */
// Types, constants and the byte-wide CRC16 update for the key hash slot router.
// No dependencies; used by every other file of the block.
package khs_pkg;

	localparam int SLOT_W    = 14;
	localparam int NODE_W    = 4;
	localparam int CRC_W     = 16;
	localparam int CNT_W     = 5;
	localparam int MAX_NODES = 16;

	localparam logic [CRC_W-1:0] CRC_POLY   = 16'h1021;
	localparam logic [7:0]       OPEN_BYTE  = 8'h7B;
	localparam logic [7:0]       CLOSE_BYTE = 8'h7D;

	localparam logic MODE_KEY   = 1'b0;
	localparam logic MODE_ENTRY = 1'b1;

	// register index decoded from paddr[2]
	localparam logic REG_NODE_COUNT = 1'b0;

	typedef struct packed {
		logic              mode;
		logic [7:0]        key_byte;
		logic              key_last;
		logic [NODE_W-1:0] entry_index;
		logic [SLOT_W-1:0] entry_low_slot;
		logic [SLOT_W-1:0] entry_high_slot;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0] key_slot;
		logic [NODE_W-1:0] node_index;
		logic              found;
	} rsp_t;

	typedef struct packed {
		logic              en;
		logic [NODE_W-1:0] index;
		logic [SLOT_W-1:0] low;
		logic [SLOT_W-1:0] high;
	} entry_wr_t;

	function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
		input logic [7:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* design/khs_lookup.sv */
// Node range table and slot lookup: parallel range compare, lowest index wins.
// Depends on khs_pkg.
module khs_lookup (
	input  logic                       clk,
	input  khs_pkg::entry_wr_t         wr,
	input  logic [khs_pkg::CNT_W-1:0]  node_count,
	input  logic [khs_pkg::SLOT_W-1:0] slot,
	output logic [khs_pkg::NODE_W-1:0] node_index,
	output logic                       found
);

	logic [khs_pkg::SLOT_W-1:0] low_q  [khs_pkg::MAX_NODES];
	logic [khs_pkg::SLOT_W-1:0] high_q [khs_pkg::MAX_NODES];
	logic [khs_pkg::MAX_NODES-1:0] hit;

	always_ff @(posedge clk) begin
		for (int i = 0; i < khs_pkg::MAX_NODES; i++) begin
			if (wr.en && (int'(wr.index) == i)) begin
				low_q[i]  <= wr.low;
				high_q[i] <= wr.high;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < khs_pkg::MAX_NODES; i++) begin
			hit[i] = (int'(node_count) > i) && (low_q[i] <= slot) && (slot <= high_q[i]);
		end
	end

	always_comb begin
		node_index = '0;
		found      = 1'b0;
		for (int i = khs_pkg::MAX_NODES - 1; i >= 0; i--) begin
			if (hit[i]) begin
				node_index = khs_pkg::NODE_W'(i);
				found      = 1'b1;
			end
		end
	end

endmodule

/* design/key_hash_slot_node_router_core.sv */
// Key hash slot router top level: key tracking, CRC16, APB register, pipeline.
// Depends on khs_pkg and khs_lookup.
//
// Usage: requests arrive on req (valid/stall). mode 0 carries one key byte;
// the byte with key_last set closes the key and yields one response on rsp:
// the CRC16-XMODEM slot (14 bits) of the hash tag, or of the whole key when
// there is no valid tag, plus the lowest table entry covering it. mode 1
// writes one node range entry and yields nothing.
// Throughput: one request per cycle unless stalled. The response to the last
// byte passes one stage of CRC and slot select, then one stage of range
// compare, before it shows on rsp.
// Stall: while rsp is held by rsp_stall the whole pipeline freezes and
// req_stall is raised; nothing is dropped.
// Reset: key state, valid flags and node_count (to 1) are cleared. The range
// table is not cleared; entries must be written before use.
// node_count sits at byte address 0 of the APB port.
module key_hash_slot_node_router_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  khs_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output khs_pkg::rsp_t rsp,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [2:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready
);

	logic                       advance;
	logic                       accept;
	logic                       key_acc;

	logic [khs_pkg::CNT_W-1:0]  node_count_q;
	logic [khs_pkg::CRC_W-1:0]  crc_whole_q, crc_tag_q;
	logic                       open_q, close_q, cao_q;
	logic [khs_pkg::CRC_W-1:0]  crc_whole_n, crc_tag_n;
	logic                       open_n, close_n, cao_n;

	logic                       valid_s1;
	logic [khs_pkg::SLOT_W-1:0] slot_s1;
	logic                       rsp_valid_q;
	khs_pkg::rsp_t              rsp_q;

	khs_pkg::entry_wr_t         wr;
	logic [khs_pkg::NODE_W-1:0] node_index;
	logic                       found;

	assign advance   = !rsp_valid_q || !rsp_stall;
	assign req_stall = !advance;
	assign accept    = req_valid && advance;
	assign key_acc   = accept && (req.mode == khs_pkg::MODE_KEY);

	assign pready = 1'b1;
	assign prdata = (paddr[2] == khs_pkg::REG_NODE_COUNT) ?
		{{(32-khs_pkg::CNT_W){1'b0}}, node_count_q} : 32'h0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= khs_pkg::CNT_W'(1);
		end else if (psel && penable && pwrite && paddr[2] == khs_pkg::REG_NODE_COUNT) begin
			node_count_q <= pwdata[khs_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		crc_whole_n = khs_pkg::crc_byte(crc_whole_q, req.key_byte);
		crc_tag_n   = crc_tag_q;
		open_n      = open_q;
		close_n     = close_q;
		cao_n       = cao_q;
		if (req.key_byte == khs_pkg::CLOSE_BYTE) begin
			if (!close_q) begin
				close_n = 1'b1;
				cao_n   = open_q;
			end
		end else if (req.key_byte == khs_pkg::OPEN_BYTE && !open_q) begin
			open_n = 1'b1;
		end else if (open_q && !close_q) begin
			crc_tag_n = khs_pkg::crc_byte(crc_tag_q, req.key_byte);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_whole_q <= '0;
			crc_tag_q   <= '0;
			open_q      <= 1'b0;
			close_q     <= 1'b0;
			cao_q       <= 1'b0;
		end else if (key_acc) begin
			if (req.key_last) begin
				crc_whole_q <= '0;
				crc_tag_q   <= '0;
				open_q      <= 1'b0;
				close_q     <= 1'b0;
				cao_q       <= 1'b0;
			end else begin
				crc_whole_q <= crc_whole_n;
				crc_tag_q   <= crc_tag_n;
				open_q      <= open_n;
				close_q     <= close_n;
				cao_q       <= cao_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			valid_s1    <= key_acc && req.key_last;
			rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot_s1 <= cao_n ? crc_tag_n[khs_pkg::SLOT_W-1:0]
				: crc_whole_n[khs_pkg::SLOT_W-1:0];
			rsp_q.key_slot   <= slot_s1;
			rsp_q.node_index <= node_index;
			rsp_q.found      <= found;
		end
	end

	assign wr.en    = accept && (req.mode == khs_pkg::MODE_ENTRY);
	assign wr.index = req.entry_index;
	assign wr.low   = req.entry_low_slot;
	assign wr.high  = req.entry_high_slot;

	khs_lookup u_lookup (
		.clk        (clk),
		.wr         (wr),
		.node_count (node_count_q),
		.slot       (slot_s1),
		.node_index (node_index),
		.found      (found)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* design/khs_router_checks.sv */
// Port-level checks for the key hash slot router, bound to the top level.
// Depends on khs_pkg and key_hash_slot_node_router_core.
module khs_router_checks (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input khs_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input khs_pkg::rsp_t rsp
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.found |-> rsp.node_index == '0)
		else $error("miss with non-zero node index");

	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> !req_stall)
		else $error("request stalled with empty output");

	a_last_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.mode == khs_pkg::MODE_KEY && req.key_last)
		##1 !rsp_stall |=> rsp_valid)
		else $error("no response after last key byte");

endmodule

bind key_hash_slot_node_router_core khs_router_checks u_checks (.*);
